// ----- hw/rtl/pdrxf_pkg.sv -----
// pdrxf_pkg: types and constants for the usb-pd receive packet framer
// no dependencies; imported by pd_rx_packet_framer_top

package pdrxf_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_TOKEN_MASK  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOP_CODE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SOP_P_CODE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SOP_PP_CODE = 2'd3;

    // sop kinds
    localparam logic [1:0] KIND_SOP    = 2'd0;
    localparam logic [1:0] KIND_SOP_P  = 2'd1;
    localparam logic [1:0] KIND_SOP_PP = 2'd2;

    // framer phases
    localparam logic PH_HUNT = 1'b0;
    localparam logic PH_BODY = 1'b1;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = 3;

    localparam logic [5:0]  FIXED_BYTES     = 6'd6;   // header + crc
    localparam logic [5:0]  MAX_PKT_BYTES   = 6'd34;
    localparam logic [15:0] PD_SVID         = 16'hFF00;
    localparam logic [4:0]  VDM_CMD_DISC_ID = 5'd1;
    localparam logic [1:0]  VDM_TYPE_ACK    = 2'd1;
    localparam logic [2:0]  MIN_ID_OBJS     = 3'd2;

    typedef struct packed {
        logic        truncated;
        logic [1:0]  sop_kind;
        logic [15:0] vendor_id;
        logic        identity_ack;
        logic [2:0]  data_objects;
        logic [5:0]  packet_bytes;
    } result_t;

endpackage

// ----- hw/rtl/pd_rx_packet_framer_top.sv -----
// pd_rx_packet_framer_top: usb-pd receive byte stream framer with result skid stage
// depends on pdrxf_pkg
//
//  channel | dir | tdata                                  | tuser            | tlast
//  s_      | in  | [7:0] rx_byte                          | -                | end_of_buffer
//  m_      | out | [5:0] bytes [8:6] objs [9] ack         | [1:0] sop_kind   | -
//          |     | [25:10] vendor_id, [31:26] zero        | [2] truncated    |
//  cfg_    | in  | cfg_index selects register, cfg_data   | -                | -
//
// one byte per clock while s_tready is high; a result is registered from the clock edge that accepts its closing byte
// a two-entry output stage (output register plus skid register) keeps s_tready
// high while one result waits; s_tready drops only when both entries are full
// synchronous active-low reset returns the framer to hunting and empties the output stage
// cfg_ready is always high

module pd_rx_packet_framer_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [pdrxf_pkg::S_TDATA_W-1:0]     s_tdata,   // [7:0] rx_byte
    input  logic                                s_tlast,   // end_of_buffer
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [pdrxf_pkg::M_TDATA_W-1:0]     m_tdata,   // packet_bytes, data_objects,
                                                           // identity_ack, vendor_id
    output logic [pdrxf_pkg::M_TUSER_W-1:0]     m_tuser,   // sop_kind, truncated
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pdrxf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [7:0]                          cfg_data
);
    import pdrxf_pkg::*;

    logic [7:0]  token_mask_reg, sop_code_reg, sop_p_code_reg, sop_pp_code_reg;
    logic        phase_reg, phase_next;
    logic [1:0]  kind_reg, kind_next;
    logic [5:0]  index_reg, index_next;
    logic [15:0] hdr_reg, hdr_next;
    logic [31:0] vdm_reg, vdm_next;
    logic [15:0] vid_reg, vid_next;

    logic        out_valid_reg, skid_valid_reg;
    result_t     out_reg, skid_reg;

    logic        in_fire;
    logic        res_valid;
    result_t     res;
    logic [7:0]  masked;
    logic        tok_hit;
    logic [1:0]  tok_kind;
    logic [5:0]  got;
    logic [2:0]  objs;
    logic [5:0]  total;
    logic        complete;
    logic        ack;
    logic        out_load;

    assign cfg_ready = 1'b1;
    assign s_tready  = !skid_valid_reg;
    assign in_fire   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            token_mask_reg  <= 8'hE0;
            sop_code_reg    <= 8'hE0;
            sop_p_code_reg  <= 8'hC0;
            sop_pp_code_reg <= 8'hA0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_TOKEN_MASK:  token_mask_reg  <= cfg_data;
                CFG_SOP_CODE:    sop_code_reg    <= cfg_data;
                CFG_SOP_P_CODE:  sop_p_code_reg  <= cfg_data;
                CFG_SOP_PP_CODE: sop_pp_code_reg <= cfg_data;
            endcase
        end
    end

    // token match, first match wins
    always_comb begin
        masked   = s_tdata & token_mask_reg;
        tok_hit  = 1'b1;
        tok_kind = KIND_SOP;
        if (masked == sop_code_reg) begin
            tok_kind = KIND_SOP;
        end else if (masked == sop_p_code_reg) begin
            tok_kind = KIND_SOP_P;
        end else if (masked == sop_pp_code_reg) begin
            tok_kind = KIND_SOP_PP;
        end else begin
            tok_hit = 1'b0;
        end
    end

    // body byte capture
    always_comb begin
        hdr_next = hdr_reg;
        vdm_next = vdm_reg;
        vid_next = vid_reg;
        case (index_reg)
            6'd0: hdr_next[7:0]    = s_tdata;
            6'd1: hdr_next[15:8]   = s_tdata;
            6'd2: vdm_next[7:0]    = s_tdata;
            6'd3: vdm_next[15:8]   = s_tdata;
            6'd4: vdm_next[23:16]  = s_tdata;
            6'd5: vdm_next[31:24]  = s_tdata;
            6'd6: vid_next[7:0]    = s_tdata;
            6'd7: vid_next[15:8]   = s_tdata;
            default: ;
        endcase
        got      = index_reg + 6'd1;
        objs     = hdr_next[14:12];
        total    = FIXED_BYTES + {1'b0, objs, 2'b00};
        complete = (got >= 6'd2) && (got == total);
        ack      = (objs >= MIN_ID_OBJS) && (vdm_next[31:16] == PD_SVID)
                   && (vdm_next[4:0] == VDM_CMD_DISC_ID) && (vdm_next[7:6] == VDM_TYPE_ACK);
    end

    always_comb begin
        phase_next = phase_reg;
        kind_next  = kind_reg;
        index_next = index_reg;
        res_valid  = 1'b0;
        res        = '0;
        res.sop_kind = kind_reg;
        unique case (phase_reg)
            PH_HUNT: begin
                if (tok_hit) begin
                    kind_next    = tok_kind;
                    index_next   = '0;
                    res.sop_kind = tok_kind;
                    if (s_tlast) begin
                        res_valid     = 1'b1;
                        res.truncated = 1'b1;
                    end else begin
                        phase_next = PH_BODY;
                    end
                end
            end
            PH_BODY: begin
                index_next = got;
                if (complete) begin
                    phase_next       = PH_HUNT;
                    res_valid        = 1'b1;
                    res.packet_bytes = total;
                    res.data_objects = objs;
                    res.identity_ack = ack;
                    res.vendor_id    = ack ? vid_next : 16'd0;
                end else if (s_tlast) begin
                    phase_next       = PH_HUNT;
                    res_valid        = 1'b1;
                    res.truncated    = 1'b1;
                    res.packet_bytes = got;
                    res.data_objects = (got >= 6'd2) ? objs : 3'd0;
                end
            end
        endcase
        if (!in_fire) begin
            res_valid = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            kind_reg  <= KIND_SOP;
            index_reg <= '0;
        end else if (in_fire) begin
            phase_reg <= phase_next;
            kind_reg  <= kind_next;
            index_reg <= index_next;
        end
    end

    // header words are cleared at each byte accepted while hunting, so a token starts them from zero
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            if (phase_reg == PH_HUNT) begin
                hdr_reg <= '0;
                vdm_reg <= '0;
                vid_reg <= '0;
            end else begin
                hdr_reg <= hdr_next;
                vdm_reg <= vdm_next;
                vid_reg <= vid_next;
            end
        end
    end

    // output register with skid entry
    assign out_load = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_load) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= res_valid;
            end
        end else if (res_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_reg <= skid_valid_reg ? skid_reg : res;
        end else if (res_valid) begin
            skid_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_reg.vendor_id, out_reg.identity_ack,
                       out_reg.data_objects, out_reg.packet_bytes};
    assign m_tuser  = {out_reg.truncated, out_reg.sop_kind};

`ifndef ASSERT_OFF
    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a result while output register is empty");

    a_index_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_BODY) |-> (index_reg < MAX_PKT_BYTES))
        else $error("byte index ran past the longest packet");

    a_complete_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_reg.truncated)
        |-> (out_reg.packet_bytes == FIXED_BYTES + {1'b0, out_reg.data_objects, 2'b00}))
        else $error("complete packet length does not match its object count");

    a_ack_objs: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.identity_ack)
        |-> (!out_reg.truncated && out_reg.data_objects >= MIN_ID_OBJS))
        else $error("identity ack reported on a short or truncated packet");
`endif

endmodule
